// ===== rtl/core/simplex_pair_quadrature_point_map_defines.svh =====
// ----------------------------------------------------------------------------
// Simplex pair quadrature point map: assertion macros
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLEX_PAIR_QUADRATURE_POINT_MAP_DEFINES_SVH
`define SIMPLEX_PAIR_QUADRATURE_POINT_MAP_DEFINES_SVH
`ifndef SYNTH
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/spqpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Simplex pair quadrature point map: package
// Item types, micro-op format, fixed-point helpers and the program builder.
// ----------------------------------------------------------------------------
package spqpm_pkg;

    localparam int MAX_DIM_DEF = 4;
    localparam int NUM_OPS     = 44;
    localparam int OPS_W       = $clog2(NUM_OPS);
    localparam int NREG        = 11;

    // Register file slots of one point in flight; R_ONE reads as the constant one.
    localparam int R_W   = 8;
    localparam int R_SG  = 9;
    localparam int R_TMP = 10;
    localparam int R_ONE = 11;

    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam logic [1:0] CFG_DIM = 2'd0;
    localparam logic [1:0] CFG_K   = 2'd1;
    localparam logic [1:0] CFG_J   = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_SUB,
        OP_NEG,
        OP_SWP,
        OP_SWC
    } op_code_t;

    typedef struct packed {
        op_code_t   code;
        logic [3:0] dst;
        logic [3:0] a;
        logic [3:0] b;
    } op_t;

    typedef op_t [NUM_OPS-1:0] prog_t;

    typedef logic [NREG-1:0][31:0] file_t;

    typedef struct packed {
        file_t      f;
        logic [1:0] copy;
        logic       clast;
        logic       rend;
    } pipe_t;

    typedef struct packed {
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
        logic signed [31:0] coord_4;
        logic signed [31:0] coord_5;
        logic signed [31:0] coord_6;
        logic signed [31:0] coord_7;
        logic signed [31:0] weight_in;
        logic               last_point;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic signed [31:0] out_4;
        logic signed [31:0] out_5;
        logic signed [31:0] out_6;
        logic signed [31:0] out_7;
        logic signed [31:0] weight_out;
        logic               copy_last;
        logic               rule_end;
    } result_t;

    function automatic logic signed [31:0] qsat(input logic signed [63:0] v);
        if (v > 64'(Q_MAX)) begin
            return Q_MAX;
        end
        if (v < 64'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Product rounded to nearest, ties toward plus infinity, then saturated.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = (p + 64'sd536870912) >>> 30;
        return qsat(p);
    endfunction

    function automatic logic signed [31:0] rd(input file_t f, input logic [3:0] idx);
        if (idx == 4'(R_ONE)) begin
            return Q_ONE;
        end
        if (idx < 4'(NREG)) begin
            return f[idx];
        end
        return '0;
    endfunction

    function automatic void swp(inout file_t f, input logic [3:0] x, input logic [3:0] y);
        logic [31:0] h;
        h = f[x];
        f[x] = f[y];
        f[y] = h;
    endfunction

    // One micro-op on one point.
    function automatic pipe_t exec_op(input pipe_t p, input op_t op);
        pipe_t              q;
        logic signed [31:0] a;
        logic signed [31:0] b;
        q = p;
        a = rd(p.f, op.a);
        b = rd(p.f, op.b);
        case (op.code)
            OP_MUL: q.f[op.dst] = qmul(a, b);
            OP_SUB: q.f[op.dst] = qsat(64'(a) - 64'(b));
            OP_NEG: q.f[op.dst] = qsat(64'sd0 - 64'(a));
            OP_SWP: swp(q.f, op.a, op.b);
            OP_SWC:
            begin
                if (p.copy == 2'd1) begin
                    swp(q.f, 4'd0, op.a);
                end else if (p.copy == 2'd2) begin
                    swp(q.f, 4'd0, op.b);
                end
            end
            default: q = p;
        endcase
        return q;
    endfunction

    function automatic op_t mk(input op_code_t c, input int dst, input int a, input int b);
        op_t o;
        o.code = c;
        o.dst  = 4'(dst);
        o.a    = 4'(a);
        o.b    = 4'(b);
        return o;
    endfunction

    function automatic void emit(inout prog_t p, inout int pc, input op_t o);
        if (pc < NUM_OPS) begin
            p[OPS_W'(pc)] = o;
        end
        pc++;
    endfunction

    function automatic void c2s(inout prog_t p, inout int pc, input int s, input int e);
        for (int i = 0; i < 8; i++) begin
            if (i >= s + 1 && i <= e) emit(p, pc, mk(OP_MUL, i, i, i - 1));
        end
        for (int i = 0; i < 8; i++) begin
            if (i >= s + 1 && i <= e) emit(p, pc, mk(OP_MUL, R_W, R_W, i - 1));
        end
        for (int i = 0; i < 8; i++) begin
            if (i >= s && i <= e - 1) emit(p, pc, mk(OP_SUB, i, i, i + 1));
        end
    endfunction

    // Weight times x to the n-th power, the power built up in the scratch slot.
    function automatic void pow_w(inout prog_t p, inout int pc, input int x, input int n);
        if (n >= 1) begin
            emit(p, pc, mk(OP_MUL, R_TMP, x, R_ONE));
            for (int i = 0; i < 8; i++) begin
                if (i < n - 1) emit(p, pc, mk(OP_MUL, R_TMP, R_TMP, x));
            end
            emit(p, pc, mk(OP_MUL, R_W, R_W, R_TMP));
        end
    endfunction

    function automatic void sigma(inout prog_t p, inout int pc, input int lo, input int hi,
                                  input int pv);
        if (lo <= hi) begin
            emit(p, pc, mk(OP_SUB, R_SG, R_ONE, lo));
            for (int m = 0; m < 8; m++) begin
                if (m >= lo + 1 && m <= hi) emit(p, pc, mk(OP_SUB, R_SG, R_SG, m));
            end
            for (int m = 0; m < 8; m++) begin
                if (m >= lo && m <= hi) emit(p, pc, mk(OP_MUL, m, m, pv));
            end
            emit(p, pc, mk(OP_MUL, pv, pv, R_SG));
        end
    endfunction

    // Micro-op program for normalized d, k and j.
    function automatic prog_t build_prog(input int d, input int k, input int j);
        prog_t p;
        int    pc;
        int    a1;
        int    a2;
        int    s3;
        p  = '0;
        pc = 0;
        a1 = d - k;
        a2 = 2 * d - 2 * k + j;
        s3 = a2;
        // Origin split.
        if (k == d) begin
            emit(p, pc, mk(OP_SWP, 0, 0, j));
        end else begin
            emit(p, pc, mk(OP_MUL, a1, 0, a1));
            if (k != 0) emit(p, pc, mk(OP_MUL, a2, 0, a2));
            emit(p, pc, mk(OP_MUL, R_TMP, 0, R_ONE));
            if (k != 0) emit(p, pc, mk(OP_MUL, R_TMP, R_TMP, 0));
            emit(p, pc, mk(OP_MUL, R_W, R_W, R_TMP));
            emit(p, pc, mk(OP_SWC, 0, a1, a2));
        end
        // Separate a and b groups.
        if (k < d - 1) begin
            c2s(p, pc, 1, d - k - 1);
            pow_w(p, pc, 0, d - k - 1);
            sigma(p, pc, 1, d - k - 1, 0);
            c2s(p, pc, d - k + 1, 2 * d - 2 * k - 1);
            pow_w(p, pc, d - k, d - k - 1);
            sigma(p, pc, d - k + 1, 2 * d - 2 * k - 1, d - k);
        end
        // Shared coordinates.
        if (k > 0) begin
            pow_w(p, pc, s3, k - 1);
            if (j > 0) begin
                c2s(p, pc, 2 * d - 2 * k, s3 - 1);
                emit(p, pc, mk(OP_NEG, R_TMP, s3, s3));
                for (int m = 0; m < 8; m++) begin
                    if (m >= 2 * d - 2 * k && m < s3) emit(p, pc, mk(OP_MUL, m, m, R_TMP));
                end
            end
            if (j < k - 1) begin
                c2s(p, pc, s3 + 1, 2 * d - k - 1);
                sigma(p, pc, s3 + 1, 2 * d - k - 1, s3);
            end
            c2s(p, pc, 2 * d - k, 2 * d - 1);
            emit(p, pc, mk(OP_SUB, R_SG, R_ONE, s3));
            for (int m = 0; m < 8; m++) begin
                if (m >= s3 + 1 && m < 2 * d - k) emit(p, pc, mk(OP_SUB, R_SG, R_SG, m));
            end
            pow_w(p, pc, R_SG, k);
            for (int m = 0; m < 8; m++) begin
                if (m >= 2 * d - k && m <= 2 * d - 1) emit(p, pc, mk(OP_MUL, m, m, R_SG));
            end
            for (int m = 0; m < 8; m++) begin
                if (m >= 2 * d - k && m <= 2 * d - k + j - 1) begin
                    emit(p, pc, mk(OP_SUB, m, m, m - k));
                end
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/simplex_pair_quadrature_point_map.sv =====
// ----------------------------------------------------------------------------
// Simplex pair quadrature point map
// Maps one tensor-rule point to one to three simplex-pair subdomain points.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. It yields one copy when
// sub_k equals dim_d, two when sub_k is zero and three otherwise, and the block
// takes one copy into its pipeline per cycle; busy stays high while a point's
// copies are issued, for all but the last of them. Each copy then runs through
// NUM_OPS register stages, one saturating Q2.30 multiply, subtract or negate
// (or a swap) per stage, and appears on result for exactly one cycle with done
// high once it has left the last stage. Copies
// of one point come out in consecutive cycles, copy_last on the final one. The
// receiver cannot stall, so nothing backs up inside. The per-stage operation
// is a program register rebuilt every cycle from dim_d, sub_k and sub_j, which
// may only change while no point is in flight; cfg_ready is always high.
`include "simplex_pair_quadrature_point_map_defines.svh"

module simplex_pair_quadrature_point_map #(
    parameter int MAX_DIM = spqpm_pkg::MAX_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spqpm_pkg::item_t    in,
    output logic                done,
    output spqpm_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import spqpm_pkg::*;

    // Configuration registers.
    logic [2:0] dim_d_reg;
    logic [2:0] sub_k_reg;
    logic [1:0] sub_j_reg;

    // Clamped configuration.
    logic [2:0] d_n;
    logic [2:0] k_n;
    logic [1:0] j_n;
    logic [1:0] ncopy;

    prog_t prog_reg;

    // Front end: the held point and the copy being issued.
    item_t      hold_reg;
    item_t      hold_next;
    logic       act_reg;
    logic       act_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       is_last;
    logic       accept;
    pipe_t      entry;

    // Pipeline: stage 0 is the entry register, the last one drives result.
    logic [NUM_OPS:0] vld_reg;
    pipe_t            pipe_reg [0:NUM_OPS];
    pipe_t            stage_next [0:NUM_OPS-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dim_d_reg <= 3'd2;
            sub_k_reg <= 3'd0;
            sub_j_reg <= 2'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DIM: dim_d_reg <= cfg_data[2:0];
                CFG_K:   sub_k_reg <= cfg_data[2:0];
                CFG_J:   sub_j_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (dim_d_reg == 3'd0) begin
            d_n = 3'd1;
        end else if (dim_d_reg > 3'(MAX_DIM)) begin
            d_n = 3'(MAX_DIM);
        end else begin
            d_n = dim_d_reg;
        end
        k_n = (sub_k_reg > d_n) ? d_n : sub_k_reg;
        if (k_n == 3'd0) begin
            j_n = 2'd0;
        end else if ({1'b0, sub_j_reg} > k_n - 3'd1) begin
            j_n = 2'(k_n - 3'd1);
        end else begin
            j_n = sub_j_reg;
        end
        if (k_n == d_n) begin
            ncopy = 2'd1;
        end else if (k_n == 3'd0) begin
            ncopy = 2'd2;
        end else begin
            ncopy = 2'd3;
        end
    end

    // Program only follows configuration; the user keeps it static while busy.
    always_ff @(posedge clk)
    begin
        prog_reg <= build_prog(int'(d_n), int'(k_n), int'(j_n));
    end

    always_comb
    begin
        is_last   = (cnt_reg == ncopy - 2'd1);
        busy      = act_reg && !is_last;
        accept    = start && !busy;
        hold_next = hold_reg;
        act_next  = act_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            hold_next = in;
            act_next  = 1'b1;
            cnt_next  = 2'd0;
        end else if (act_reg && !is_last) begin
            cnt_next = cnt_reg + 2'd1;
        end else begin
            act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Coordinates beyond 2*dim_d enter as zero and are never written.
    always_comb
    begin
        logic [3:0] n2;
        n2 = {d_n, 1'b0};
        entry.f[0] = hold_reg.coord_0;
        entry.f[1] = hold_reg.coord_1;
        entry.f[2] = (n2 > 4'd2) ? hold_reg.coord_2 : '0;
        entry.f[3] = (n2 > 4'd3) ? hold_reg.coord_3 : '0;
        entry.f[4] = (n2 > 4'd4) ? hold_reg.coord_4 : '0;
        entry.f[5] = (n2 > 4'd5) ? hold_reg.coord_5 : '0;
        entry.f[6] = (n2 > 4'd6) ? hold_reg.coord_6 : '0;
        entry.f[7] = (n2 > 4'd7) ? hold_reg.coord_7 : '0;
        entry.f[R_W]   = hold_reg.weight_in;
        entry.f[R_SG]  = '0;
        entry.f[R_TMP] = '0;
        entry.copy  = cnt_reg;
        entry.clast = is_last;
        entry.rend  = is_last && hold_reg.last_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NUM_OPS-1:0], act_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= entry;
    end

    for (genvar s = 0; s < NUM_OPS; s++) begin : g_stage
        always_comb
        begin
            stage_next[s] = exec_op(pipe_reg[s], prog_reg[s]);
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[s+1] <= stage_next[s];
        end
    end

    assign done              = vld_reg[NUM_OPS];
    assign result.out_0      = pipe_reg[NUM_OPS].f[0];
    assign result.out_1      = pipe_reg[NUM_OPS].f[1];
    assign result.out_2      = pipe_reg[NUM_OPS].f[2];
    assign result.out_3      = pipe_reg[NUM_OPS].f[3];
    assign result.out_4      = pipe_reg[NUM_OPS].f[4];
    assign result.out_5      = pipe_reg[NUM_OPS].f[5];
    assign result.out_6      = pipe_reg[NUM_OPS].f[6];
    assign result.out_7      = pipe_reg[NUM_OPS].f[7];
    assign result.weight_out = pipe_reg[NUM_OPS].f[R_W];
    assign result.copy_last  = pipe_reg[NUM_OPS].clast;
    assign result.rule_end   = pipe_reg[NUM_OPS].rend;

    // Busy only while copies of a held point remain to be issued.
    `SPQ_ASSERT_IMP(a_busy_active, busy, act_reg)
    // An accepted point starts issuing at its first copy.
    `SPQ_ASSERT_NXT(a_accept_issue, accept, act_reg && cnt_reg == 2'd0)
    // Copies of one point leave in consecutive cycles.
    `SPQ_ASSERT_NXT(a_copies_together, done && !result.copy_last, done)
    // A rule end is always carried on the last copy of its point.
    `SPQ_ASSERT_IMP(a_end_on_last, done && result.rule_end, result.copy_last)

endmodule

// ===== verif/spqpm_checker.sv =====
// ----------------------------------------------------------------------------
// Simplex pair quadrature point map: checker
// Watches the configuration, item and result channels, predicts the mapped
// copies of every accepted point and compares them in order.
// ----------------------------------------------------------------------------
module spqpm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  spqpm_pkg::item_t    in,
    input  logic                done,
    input  spqpm_pkg::result_t  result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import spqpm_pkg::*;

    typedef longint coord_vec_t [8];

    localparam longint ONE_Q = 64'sd1073741824;
    localparam longint MAX_Q = 64'sd2147483647;
    localparam longint MIN_Q = -64'sd2147483648;

    logic [2:0] dim_reg;
    logic [2:0] k_reg;
    logic [1:0] j_reg;
    result_t    copies_due[$];

    function automatic longint fx_sat(input longint v);
        if (v > MAX_Q) return MAX_Q;
        if (v < MIN_Q) return MIN_Q;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return fx_sat((a * b + 64'sd536870912) >>> 30);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return fx_sat(a - b);
    endfunction

    function automatic longint fx_pow(input longint x, input int n);
        longint r;
        r = ONE_Q;
        for (int i = 0; i < n; i++) r = fx_mul(r, x);
        return r;
    endfunction

    // Cube to simplex on coordinates s..e; the weight takes the Jacobian.
    function automatic void cube_map(inout coord_vec_t t, inout longint w,
                                     input int s, input int e);
        for (int i = s + 1; i <= e; i++) t[i] = fx_mul(t[i], t[i - 1]);
        for (int i = s + 1; i <= e; i++) w = fx_mul(w, t[i - 1]);
        for (int i = s; i <= e - 1; i++) t[i] = fx_sub(t[i], t[i + 1]);
    endfunction

    // The group lo..hi is rescaled by the pivot, and the pivot by the group's remaining mass.
    function automatic void group_scale(inout coord_vec_t t, input int lo, input int hi,
                                        input int pv);
        longint sg;
        sg = ONE_Q;
        for (int m = lo; m <= hi; m++) sg = fx_sub(sg, t[m]);
        for (int m = lo; m <= hi; m++) t[m] = fx_mul(t[m], t[pv]);
        t[pv] = fx_mul(t[pv], sg);
    endfunction

    function automatic void subdomain_map(inout coord_vec_t t, inout longint w,
                                          input int d, input int k, input int j);
        int     s2;
        int     s3;
        longint sg;
        s2 = d - k;
        s3 = 2 * d - 2 * k + j;
        if (k < d - 1) begin
            cube_map(t, w, 1, d - k - 1);
            w = fx_mul(w, fx_pow(t[0], d - k - 1));
            group_scale(t, 1, d - k - 1, 0);
            cube_map(t, w, d - k + 1, 2 * d - 2 * k - 1);
            w = fx_mul(w, fx_pow(t[s2], d - k - 1));
            group_scale(t, d - k + 1, 2 * d - 2 * k - 1, s2);
        end
        if (k > 0) begin
            w = fx_mul(w, fx_pow(t[s3], k - 1));
            if (j > 0) begin
                cube_map(t, w, 2 * d - 2 * k, s3 - 1);
                for (int m = 2 * d - 2 * k; m < s3; m++) begin
                    t[m] = fx_mul(t[m], fx_sat(-t[s3]));
                end
            end
            if (j < k - 1) begin
                cube_map(t, w, s3 + 1, 2 * d - k - 1);
                group_scale(t, s3 + 1, 2 * d - k - 1, s3);
            end
            cube_map(t, w, 2 * d - k, 2 * d - 1);
            sg = fx_sub(ONE_Q, t[s3]);
            for (int m = s3 + 1; m < 2 * d - k; m++) sg = fx_sub(sg, t[m]);
            w = fx_mul(w, fx_pow(sg, k));
            for (int m = 2 * d - k; m <= 2 * d - 1; m++) t[m] = fx_mul(t[m], sg);
            for (int m = 2 * d - k; m <= 2 * d - k + j - 1; m++) t[m] = fx_sub(t[m], t[m - k]);
        end
    endfunction

    // Queues the copies that one accepted point must produce.
    function automatic void predict_copies(input item_t it);
        coord_vec_t base;
        coord_vec_t t;
        longint     wb;
        longint     w;
        longint     h;
        int         act[3];
        int         d;
        int         k;
        int         j;
        int         ncopy;
        result_t    r;
        d = int'(dim_reg);
        k = int'(k_reg);
        j = int'(j_reg);
        if (d < 1) d = 1;
        if (d > MAX_DIM_DEF) d = MAX_DIM_DEF;
        if (k > d) k = d;
        if (k == 0) j = 0;
        else if (j > k - 1) j = k - 1;
        base[0] = it.coord_0;
        base[1] = it.coord_1;
        base[2] = it.coord_2;
        base[3] = it.coord_3;
        base[4] = it.coord_4;
        base[5] = it.coord_5;
        base[6] = it.coord_6;
        base[7] = it.coord_7;
        for (int i = 2 * d; i < 8; i++) base[i] = 0;
        wb = it.weight_in;
        act[0] = 0;
        act[1] = d - k;
        act[2] = 2 * d - 2 * k + j;
        if (k == d) begin
            ncopy = 1;
            h = base[0];
            base[0] = base[j];
            base[j] = h;
        end else begin
            ncopy = (k == 0) ? 2 : 3;
            for (int i = 1; i < ncopy; i++) base[act[i]] = fx_mul(base[0], base[act[i]]);
            wb = fx_mul(wb, fx_pow(base[0], ncopy - 1));
        end
        for (int c = 0; c < ncopy; c++) begin
            t = base;
            w = wb;
            if (c > 0) begin
                h = t[0];
                t[0] = t[act[c]];
                t[act[c]] = h;
            end
            subdomain_map(t, w, d, k, j);
            r.out_0      = t[0][31:0];
            r.out_1      = t[1][31:0];
            r.out_2      = t[2][31:0];
            r.out_3      = t[3][31:0];
            r.out_4      = t[4][31:0];
            r.out_5      = t[5][31:0];
            r.out_6      = t[6][31:0];
            r.out_7      = t[7][31:0];
            r.weight_out = w[31:0];
            r.copy_last  = (c == ncopy - 1);
            r.rule_end   = (c == ncopy - 1) && it.last_point;
            copies_due.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t     want;
        logic [31:0] got_f[11];
        logic [31:0] want_f[11];
        if (!rst_n) begin
            dim_reg <= 3'd2;
            k_reg   <= 3'd0;
            j_reg   <= 2'd0;
            errors  = 0;
            copies_due.delete();
            pending = 0;
        end else begin
            if (done) begin
                if (copies_due.size() == 0) begin
                    report_mismatch("done with no copy waiting", 32'(done), 32'd0);
                end else begin
                    want = copies_due.pop_front();
                    got_f  = '{result.out_0, result.out_1, result.out_2, result.out_3,
                               result.out_4, result.out_5, result.out_6, result.out_7,
                               result.weight_out, 32'(result.copy_last),
                               32'(result.rule_end)};
                    want_f = '{want.out_0, want.out_1, want.out_2, want.out_3,
                               want.out_4, want.out_5, want.out_6, want.out_7,
                               want.weight_out, 32'(want.copy_last), 32'(want.rule_end)};
                    for (int i = 0; i < 11; i++) begin
                        if (got_f[i] !== want_f[i]) begin
                            report_mismatch(i < 8 ? $sformatf("out_%0d", i) :
                                            i == 8 ? "weight_out" :
                                            i == 9 ? "copy_last" : "rule_end",
                                            got_f[i], want_f[i]);
                        end
                    end
                end
            end
            if (start && !busy) predict_copies(in);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIM: dim_reg <= cfg_data[2:0];
                    CFG_K:   k_reg   <= cfg_data[2:0];
                    CFG_J:   j_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
            pending = copies_due.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Simplex pair quadrature point map: testbench top
// Drives configuration and points through a series of subdomain settings with
// varying idle gaps; the checker beside the block scores every result copy.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spqpm_pkg::*;

    // The index past the last register; writes to it must be ignored.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Drain margin, waited once the checker has no copy pending.
    localparam int DRAIN_CYCLES = NUM_OPS + 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       in = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_pct;

    always #5 clk = ~clk;

    simplex_pair_quadrature_point_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in        (in),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spqpm_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in        (in),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // A coordinate value: mostly inside the unit interval, where the mapping is
    // meaningful, but also negatives, corner codes and raw random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return Q_ONE - $urandom_range(0, 3);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return Q_ONE;
                    2: return Q_MAX;
                    default: return Q_MIN;
                endcase
            end
            3: return -$urandom_range(0, 32'h4000_0000);
            default: return $urandom_range(0, 32'h4000_0000);
        endcase
    endfunction

    function automatic item_t random_point();
        item_t it;
        it.coord_0    = pick_value();
        it.coord_1    = pick_value();
        it.coord_2    = pick_value();
        it.coord_3    = pick_value();
        it.coord_4    = pick_value();
        it.coord_5    = pick_value();
        it.coord_6    = pick_value();
        it.coord_7    = pick_value();
        it.weight_in  = pick_value();
        it.last_point = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Presents one point and holds it until the block takes it. Unless an idle
    // gap is drawn, the start strobe stays high so that back-to-back items need no extra assignment.
    task automatic send_point(input item_t it);
        start <= 1'b1;
        in    <= it;
        do @(posedge clk); while (busy);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            in    <= random_point();
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Registers change only with the pipeline empty.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Settings cover every case k for every dimension except k = 0 at dimension 2,
    // index extremes, and register values beyond their legal range.
    localparam int NSET = 18;
    localparam logic [7:0] SET_D [NSET] = '{1, 1, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4, 4,
                                            0, 7, 5};
    localparam logic [7:0] SET_K [NSET] = '{0, 1, 1, 1, 2, 0, 1, 2, 3, 0, 1, 2, 3, 3, 4,
                                            0, 5, 2};
    localparam logic [7:0] SET_J [NSET] = '{0, 0, 0, 3, 1, 0, 0, 1, 2, 0, 0, 1, 2, 0, 3,
                                            2, 3, 0};
    localparam int IDLE_MODE [4] = '{0, 69, 0, 17};

    initial begin
        item_t it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset setting: field extremes, all-zero, all-one
        // and alternating bit patterns, the unit point and the rule-end marker.
        idle_pct = 0;
        it = '{default: Q_MAX, last_point: 1'b0};
        send_point(it);
        it = '{default: Q_MIN, last_point: 1'b1};
        send_point(it);
        it = '{default: 32'h0, last_point: 1'b0};
        send_point(it);
        it = '{default: Q_ONE, last_point: 1'b1};
        send_point(it);
        it = '{default: 32'hffff_ffff, last_point: 1'b0};
        send_point(it);
        it = '{default: 32'h5555_5555, last_point: 1'b0};
        send_point(it);
        it = '{default: 32'haaaa_aaaa, last_point: 1'b1};
        send_point(it);
        it = '{default: 32'h2000_0000, last_point: 1'b0};
        send_point(it);
        for (int i = 0; i < 6; i++) send_point(random_point());
        drain_pipeline();

        // An out-of-list write must leave the setting alone.
        write_reg(CFG_SPARE, 8'hff);
        for (int i = 0; i < 4; i++) send_point(random_point());
        drain_pipeline();

        for (int s = 0; s < NSET; s++) begin
            write_reg(CFG_DIM, SET_D[s]);
            write_reg(CFG_K, SET_K[s]);
            write_reg(CFG_J, SET_J[s]);
            idle_pct = IDLE_MODE[s % 4];
            for (int i = 0; i < 15; i++) send_point(random_point());
            drain_pipeline();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spqpm_pkg.sv
rtl/core/simplex_pair_quadrature_point_map.sv
verif/spqpm_checker.sv
verif/tb.sv
